// File: rtl/esot_pkg.sv
`default_nettype none
package esot_pkg;

	localparam int TABLE_DEPTH_DEF = 64;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_QUERY  = 2'd2;

	// one table entry as stored in the memory
	typedef struct packed {
		logic               valid;
		logic [15:0]        key;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic [15:0]        radius;
		logic [31:0]        types;
	} entry_t;

	// one accepted request
	typedef struct packed {
		logic [1:0]         mode;
		logic [15:0]        entity_id;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic [15:0]        radius;
		logic [31:0]        type_mask;
	} cmd_t;

	// scan status toward the sequencer
	typedef struct packed {
		logic busy;
		logic hit;
		logic key_found;
		logic free_found;
	} scan_stat_t;

endpackage
`default_nettype wire

// File: rtl/esot_req_if.sv
`default_nettype none
interface esot_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [15:0]        entity_id;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [15:0] pos_z;
	logic [15:0]        radius;
	logic [31:0]        type_mask;

	modport source (output valid, mode, entity_id, pos_x, pos_y, pos_z, radius, type_mask,
		input ready);
	modport sink (input valid, mode, entity_id, pos_x, pos_y, pos_z, radius, type_mask,
		output ready);
endinterface
`default_nettype wire

// File: rtl/esot_rsp_if.sv
`default_nettype none
interface esot_rsp_if;
	logic valid;
	logic ready;
	logic hit;
	logic table_full;

	modport source (output valid, hit, table_full, input ready);
	modport sink (input valid, hit, table_full, output ready);
endinterface
`default_nettype wire

// File: rtl/esot_ram.sv
`default_nettype none
module esot_ram #(
	parameter int DEPTH = esot_pkg::TABLE_DEPTH_DEF,
	parameter int AW    = 6
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [AW-1:0]   wr_addr,
	input  wire esot_pkg::entry_t wr_data,
	input  wire logic            rd_en,
	input  wire logic [AW-1:0]   rd_addr,
	output esot_pkg::entry_t     rd_data
);

	esot_pkg::entry_t mem [DEPTH];
	esot_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

// File: rtl/esot_scan.sv
`default_nettype none
module esot_scan #(
	parameter int AW = 6
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             issue,
	input  wire logic [AW-1:0]    issue_idx,
	input  wire esot_pkg::cmd_t   cmd,
	input  wire esot_pkg::entry_t rd_data,
	output esot_pkg::scan_stat_t  stat,
	output logic [AW-1:0]         key_idx,
	output logic [AW-1:0]         free_idx
);

	logic            s1_vld;
	logic [AW-1:0]   idx_s1;

	logic            hv_s2;
	logic [15:0]     ax_s2, ay_s2, az_s2;
	logic [16:0]     rsum_s2;

	logic            hv_s3;
	logic [31:0]     sqx_s3, sqy_s3, sqz_s3;
	logic [33:0]     r2_s3;

	logic            hit_q, key_found_q, free_found_q;
	logic [AW-1:0]   key_idx_q, free_idx_q;

	logic signed [16:0] dx, dy, dz;
	logic [16:0]        mx, my, mz;
	logic               qual;
	logic [33:0]        d2;

	always_comb begin
		dx = {rd_data.pos_x[15], rd_data.pos_x} - {cmd.pos_x[15], cmd.pos_x};
		dy = {rd_data.pos_y[15], rd_data.pos_y} - {cmd.pos_y[15], cmd.pos_y};
		dz = {rd_data.pos_z[15], rd_data.pos_z} - {cmd.pos_z[15], cmd.pos_z};
		mx = dx[16] ? 17'(-dx) : 17'(dx);
		my = dy[16] ? 17'(-dy) : 17'(dy);
		mz = dz[16] ? 17'(-dz) : 17'(dz);
		qual = s1_vld && rd_data.valid && (cmd.mode == esot_pkg::MODE_QUERY)
			&& ((rd_data.types & cmd.type_mask) != 32'd0);
		d2 = 34'(sqx_s3) + 34'(sqy_s3) + 34'(sqz_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld <= 1'b0;
			hv_s2  <= 1'b0;
			hv_s3  <= 1'b0;
		end else begin
			s1_vld <= issue;
			hv_s2  <= qual;
			hv_s3  <= hv_s2;
		end
	end

	// payload stages, |diff| fits 16 bits
	always_ff @(posedge clk) begin
		idx_s1  <= issue_idx;
		ax_s2   <= mx[15:0];
		ay_s2   <= my[15:0];
		az_s2   <= mz[15:0];
		rsum_s2 <= {1'b0, rd_data.radius} + {1'b0, cmd.radius};
		sqx_s3  <= 32'(ax_s2) * 32'(ax_s2);
		sqy_s3  <= 32'(ay_s2) * 32'(ay_s2);
		sqz_s3  <= 32'(az_s2) * 32'(az_s2);
		r2_s3   <= 34'(rsum_s2) * 34'(rsum_s2);
	end

	// indices arrive in ascending order, so the first match is the lowest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q        <= 1'b0;
			key_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if (start) begin
			hit_q        <= 1'b0;
			key_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			if (hv_s3 && (d2 < r2_s3)) begin
				hit_q <= 1'b1;
			end
			if (s1_vld && rd_data.valid && (rd_data.key == cmd.entity_id) && !key_found_q) begin
				key_found_q <= 1'b1;
			end
			if (s1_vld && !rd_data.valid && !free_found_q) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_vld && rd_data.valid && (rd_data.key == cmd.entity_id) && !key_found_q) begin
			key_idx_q <= idx_s1;
		end
		if (s1_vld && !rd_data.valid && !free_found_q) begin
			free_idx_q <= idx_s1;
		end
	end

	assign stat.busy       = s1_vld | hv_s2 | hv_s3;
	assign stat.hit        = hit_q;
	assign stat.key_found  = key_found_q;
	assign stat.free_found = free_found_q;
	assign key_idx         = key_idx_q;
	assign free_idx        = free_idx_q;

endmodule
`default_nettype wire

// File: rtl/emitter_sphere_overlap_table_unit.sv
// Emitter table with sphere overlap queries.
// req channel (valid/ready): mode, entity_id, pos_x/y/z, radius, type_mask.
//   mode 0 inserts or updates the emitter keyed by entity_id, mode 1 removes
//   it, mode 2 asks for any valid emitter of a shared type strictly inside
//   the summed radii. Other modes answer zero and change nothing.
// rsp channel (valid/ready): hit, table_full; exactly one per request.
// Every request sweeps the whole table memory, one entry read per cycle, then
// drains the distance pipe; the table write and the response follow in the
// finish state. One request is in flight at a time, so a new one is taken
// only after the previous one leaves the finish state. The single memory read
// port sets the pace of the sweep.
// The response sits in an output register; the next request is taken while it
// waits. If the receiver stalls with a response still held, the following
// request finishes its sweep and then waits until the register frees up.
// After reset the block clears the valid flag of every entry, one entry per
// cycle, and req.ready stays low until the last entry is cleared.
`default_nettype none
module emitter_sphere_overlap_table_unit #(
	parameter int TABLE_DEPTH = esot_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	esot_req_if.sink   req,
	esot_rsp_if.source rsp
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_DRAIN  = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t               state_q;
	logic [AW-1:0]        idx_q;
	esot_pkg::cmd_t       cmd_q;
	logic                 rsp_vld_q, hit_q, full_q;

	esot_pkg::scan_stat_t scan_stat;
	logic [AW-1:0]        key_idx, free_idx;
	esot_pkg::entry_t     rd_data, wr_data;
	logic                 ram_we;
	logic [AW-1:0]        wr_addr;
	logic                 accept, finish_go, issue;
	logic                 res_hit, res_full;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign issue     = (state_q == ST_SCAN);
	assign finish_go = (state_q == ST_FINISH) && (!rsp_vld_q || rsp.ready);

	always_comb begin
		res_hit  = 1'b0;
		res_full = 1'b0;
		ram_we   = 1'b0;
		wr_addr  = idx_q;
		wr_data  = '0;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_FINISH: begin
				wr_data.valid  = (cmd_q.mode == esot_pkg::MODE_INSERT);
				wr_data.key    = cmd_q.entity_id;
				wr_data.pos_x  = cmd_q.pos_x;
				wr_data.pos_y  = cmd_q.pos_y;
				wr_data.pos_z  = cmd_q.pos_z;
				wr_data.radius = cmd_q.radius;
				wr_data.types  = cmd_q.type_mask;
				wr_addr        = scan_stat.key_found ? key_idx : free_idx;
				case (cmd_q.mode)
					esot_pkg::MODE_INSERT: begin
						res_full = !scan_stat.key_found && !scan_stat.free_found;
						ram_we   = finish_go && !res_full;
					end
					esot_pkg::MODE_REMOVE: begin
						ram_we = finish_go && scan_stat.key_found;
					end
					esot_pkg::MODE_QUERY: begin
						res_hit = scan_stat.hit;
					end
					default: begin
						res_hit = 1'b0;
					end
				endcase
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					idx_q <= '0;
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!scan_stat.busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (finish_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.mode      <= req.mode;
			cmd_q.entity_id <= req.entity_id;
			cmd_q.pos_x     <= req.pos_x;
			cmd_q.pos_y     <= req.pos_y;
			cmd_q.pos_z     <= req.pos_z;
			cmd_q.radius    <= req.radius;
			cmd_q.type_mask <= req.type_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (finish_go) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_go) begin
			hit_q  <= res_hit;
			full_q <= res_full;
		end
	end

	assign rsp.valid      = rsp_vld_q;
	assign rsp.hit        = hit_q;
	assign rsp.table_full = full_q;

	esot_ram #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (issue),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	esot_scan #(
		.AW (AW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.issue     (issue),
		.issue_idx (idx_q),
		.cmd       (cmd_q),
		.rd_data   (rd_data),
		.stat      (scan_stat),
		.key_idx   (key_idx),
		.free_idx  (free_idx)
	);

`ifndef SYNTHESIS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_DRAIN) |-> !ram_we)
		else $error("table written during a sweep");

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_SCAN) && !rsp_vld_q || (state_q == ST_SCAN))
		else $error("accepted transaction did not start a sweep");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !scan_stat.busy)
		else $error("scan pipe busy while idle");

	a_rsp_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.hit && rsp.table_full))
		else $error("hit and table_full both set");
`endif

endmodule
`default_nettype wire
